// ===== rtl/core/u2d_pkg.sv =====
// ----------------------------------------------------------------------------
// u2d_pkg
// Shared constants, types and the character class function of the 8.3
// short-name converter.
// ----------------------------------------------------------------------------
package u2d_pkg;

    localparam int NAME_CHARS = 8;
    localparam int EXT_CHARS  = 3;
    localparam int POS_W      = 4;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    localparam logic [POS_W-1:0] NAME_LIMIT = POS_W'(NAME_CHARS);
    localparam logic [POS_W-1:0] EXT_LIMIT  = POS_W'(EXT_CHARS);

    // Outcome of mapping one byte.
    typedef struct packed {
        logic [7:0] mapped;
        logic       folded;
        logic       replaced;
    } t_char_map;

    // One result beat.
    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_char;
        logic       name_done;
        logic       truncated;
        logic       case_converted;
        logic       bad_char_replaced;
        logic       rejected;
    } t_result;

    // Lower-case letters, digits and _^$~!#%&-{}'`()@ pass unchanged.
    function automatic logic in_allowed(input logic [7:0] c);
        logic ok;
        ok = 1'b0;
        if (c >= 8'h61 && c <= 8'h7A) begin
            ok = 1'b1;
        end
        if (c >= 8'h30 && c <= 8'h39) begin
            ok = 1'b1;
        end
        unique case (c)
            8'h5F, 8'h5E, 8'h24, 8'h7E, 8'h21, 8'h23, 8'h25, 8'h26,
            8'h2D, 8'h7B, 8'h7D, 8'h27, 8'h60, 8'h28, 8'h29, 8'h40: begin
                ok = 1'b1;
            end
            default: begin
            end
        endcase
        return ok;
    endfunction

endpackage

// ===== rtl/core/unix_to_dos_short_name.sv =====
// ----------------------------------------------------------------------------
// unix_to_dos_short_name
// Each result beat is registered into a two-entry output buffer (main and
// skid). Throughput: one byte per cycle while the skid entry is empty; the
// per-name phase and counter update in the same cycle the byte is taken, and
// the buffer keeps input accepted for one beat while the output stalls.
// Reset: synchronous active low; state returns to the start of a name and
// both output entries are emptied.
// ----------------------------------------------------------------------------
module unix_to_dos_short_name
    import u2d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_char_code,
    input  logic       i_last_char,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic       o_out_valid,
    output logic [7:0] o_out_char,
    output logic       o_name_done,
    output logic       o_truncated,
    output logic       o_case_converted,
    output logic       o_bad_char_replaced,
    output logic       o_rejected
);

    typedef enum logic {PH_NAME, PH_EXT} t_phase;

    t_phase           r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_trunc, n_trunc;
    logic             r_case, n_case;
    logic             r_bad, n_bad;
    logic             r_first, n_first;
    logic             r_rej, n_rej;

    t_result r_main, r_skid, n_res;
    logic    r_main_vld, r_skid_vld;

    t_char_map cmap;
    logic      in_acc, out_acc;

    u2d_char_map u_map (
        .i_char (i_char_code),
        .o_map  (cmap)
    );

    assign o_in_ready = !r_skid_vld;
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_acc    = r_main_vld && i_res_ready;

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_trunc = r_trunc;
        n_case  = r_case;
        n_bad   = r_bad;
        n_first = r_first;
        n_rej   = r_rej;
        n_res   = '0;
        if (i_char_code != CH_NUL && !r_rej) begin
            n_first = 1'b0;
            if (r_first && i_char_code == CH_DOT) begin
                n_rej = 1'b1;
            end else if (r_phase == PH_NAME) begin
                if (i_char_code == CH_DOT) begin
                    n_res.out_valid = 1'b1;
                    n_res.out_char  = CH_DOT;
                    n_phase         = PH_EXT;
                    n_pos           = '0;
                end else if (r_pos < NAME_LIMIT) begin
                    n_res.out_valid = 1'b1;
                    n_res.out_char  = cmap.mapped;
                    n_case          = r_case | cmap.folded;
                    n_bad           = r_bad | cmap.replaced;
                    n_pos           = r_pos + 1'b1;
                end else begin
                    n_trunc = 1'b1;
                end
            end else begin
                if (i_char_code == CH_DOT || r_pos >= EXT_LIMIT) begin
                    n_rej = 1'b1;
                end else begin
                    n_res.out_valid = 1'b1;
                    n_res.out_char  = cmap.mapped;
                    n_case          = r_case | cmap.folded;
                    n_bad           = r_bad | cmap.replaced;
                    n_pos           = r_pos + 1'b1;
                end
            end
        end
        n_res.name_done         = i_last_char;
        n_res.truncated         = n_trunc;
        n_res.case_converted    = n_case;
        n_res.bad_char_replaced = n_bad;
        n_res.rejected          = n_rej;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_NAME;
            r_pos      <= '0;
            r_trunc    <= 1'b0;
            r_case     <= 1'b0;
            r_bad      <= 1'b0;
            r_first    <= 1'b1;
            r_rej      <= 1'b0;
            r_main_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                if (i_last_char) begin
                    r_phase <= PH_NAME;
                    r_pos   <= '0;
                    r_trunc <= 1'b0;
                    r_case  <= 1'b0;
                    r_bad   <= 1'b0;
                    r_first <= 1'b1;
                    r_rej   <= 1'b0;
                end else begin
                    r_phase <= n_phase;
                    r_pos   <= n_pos;
                    r_trunc <= n_trunc;
                    r_case  <= n_case;
                    r_bad   <= n_bad;
                    r_first <= n_first;
                    r_rej   <= n_rej;
                end
            end
            // The skid entry only fills while the main entry is held.
            if (!r_main_vld || out_acc) begin
                if (r_skid_vld) begin
                    r_main     <= r_skid;
                    r_skid_vld <= 1'b0;
                end else begin
                    r_main     <= n_res;
                    r_main_vld <= in_acc;
                end
            end else if (in_acc) begin
                r_skid     <= n_res;
                r_skid_vld <= 1'b1;
            end
        end
    end

    assign o_res_valid         = r_main_vld;
    assign o_out_valid         = r_main.out_valid;
    assign o_out_char          = r_main.out_char;
    assign o_name_done         = r_main.name_done;
    assign o_truncated         = r_main.truncated;
    assign o_case_converted    = r_main.case_converted;
    assign o_bad_char_replaced = r_main.bad_char_replaced;
    assign o_rejected          = r_main.rejected;

    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_main_vld)
        else $error("skid entry holds a beat while the main entry is empty");

    a_reject_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_main_vld && r_main.rejected |-> !r_main.out_valid)
        else $error("character emitted on a rejected name");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_NAME && r_pos <= NAME_LIMIT)
        || (r_phase == PH_EXT && r_pos <= EXT_LIMIT))
        else $error("position count beyond its field limit");

    a_name_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_last_char |=> r_first && r_pos == '0 && !r_rej && !r_trunc)
        else $error("per-name state not cleared after the last byte");

endmodule

// ===== rtl/core/u2d_char_map.sv =====
// ----------------------------------------------------------------------------
// u2d_char_map
// Maps one file-name byte to its short-name character: allowed bytes pass,
// upper-case letters fold to lower case, everything else becomes '$'.
// ----------------------------------------------------------------------------
module u2d_char_map
    import u2d_pkg::*;
(
    input  logic [7:0] i_char,
    output t_char_map  o_map
);

    always_comb begin
        o_map = '{mapped: i_char, folded: 1'b0, replaced: 1'b0};
        if (in_allowed(i_char)) begin
            o_map.mapped = i_char;
        end else if (i_char >= CH_UPPER_A && i_char <= CH_UPPER_Z) begin
            o_map.mapped = i_char + CASE_OFFSET;
            o_map.folded = 1'b1;
        end else begin
            o_map.mapped   = CH_DOLLAR;
            o_map.replaced = 1'b1;
        end
    end

endmodule

// ===== tb/short_name_checker.sv =====
// ----------------------------------------------------------------------------
// short_name_checker
// Watches both channels of the 8.3 short-name converter, computes the
// expected result beat for every accepted file-name byte and compares each
// accepted result beat with the oldest expected one, field by field.
// ----------------------------------------------------------------------------
module short_name_checker
    import u2d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_char_code,
    input  logic       i_last_char,
    input  logic       i_res_valid,
    input  logic       i_res_ready,
    input  logic       i_out_valid,
    input  logic [7:0] i_out_char,
    input  logic       i_name_done,
    input  logic       i_truncated,
    input  logic       i_case_converted,
    input  logic       i_bad_char_replaced,
    input  logic       i_rejected,
    output int         o_pending,
    output int         o_mismatches
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic {
        NAME_PART,
        EXT_PART
    } t_name_part;

    localparam string DOS_PUNCT = "_^$~!#%&-{}'`()@";

    t_name_part       part;
    logic [POS_W-1:0] char_pos;
    logic             trunc_seen;
    logic             case_seen;
    logic             bad_seen;
    logic             first_byte;
    logic             reject_seen;
    t_result          short_name_q[$];
    int               mismatch_cnt;

    assign o_mismatches = mismatch_cnt;

    initial begin
        mismatch_cnt = 0;
        o_pending    = 0;
    end

    function automatic logic dos_legal(input logic [7:0] c);
        logic ok;
        ok = (c >= "a" && c <= "z") || (c >= "0" && c <= "9");
        for (int i = 0; i < DOS_PUNCT.len(); i++) begin
            if (c == DOS_PUNCT[i]) begin
                ok = 1'b1;
            end
        end
        return ok;
    endfunction

    // Legal bytes pass, capitals are folded down, everything else becomes '$'.
    function automatic logic [7:0] dos_map(input logic [7:0] c);
        if (dos_legal(c)) begin
            return c;
        end
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            case_seen = 1'b1;
            return c + CASE_OFFSET;
        end
        bad_seen = 1'b1;
        return CH_DOLLAR;
    endfunction

    function automatic void clear_name_state();
        part        = NAME_PART;
        char_pos    = '0;
        trunc_seen  = 1'b0;
        case_seen   = 1'b0;
        bad_seen    = 1'b0;
        first_byte  = 1'b1;
        reject_seen = 1'b0;
    endfunction

    function automatic t_result short_name_step(input logic [7:0] c, input logic last);
        t_result r;
        logic       emit;
        logic [7:0] mapped;
        emit   = 1'b0;
        mapped = 8'h00;
        // A NUL byte is skipped entirely; it does not even clear first_byte.
        if (c != CH_NUL && !reject_seen) begin
            if (first_byte && c == CH_DOT) begin
                reject_seen = 1'b1;
            end else if (part == NAME_PART) begin
                if (c == CH_DOT) begin
                    emit     = 1'b1;
                    mapped   = CH_DOT;
                    part     = EXT_PART;
                    char_pos = '0;
                end else if (char_pos < NAME_LIMIT) begin
                    emit     = 1'b1;
                    mapped   = dos_map(c);
                    char_pos = char_pos + 1'b1;
                end else begin
                    trunc_seen = 1'b1;
                end
            end else if (c == CH_DOT || char_pos >= EXT_LIMIT) begin
                reject_seen = 1'b1;
            end else begin
                emit     = 1'b1;
                mapped   = dos_map(c);
                char_pos = char_pos + 1'b1;
            end
            first_byte = 1'b0;
        end
        r.out_valid         = emit;
        r.out_char          = mapped;
        r.name_done         = last;
        r.truncated         = trunc_seen;
        r.case_converted    = case_seen;
        r.bad_char_replaced = bad_seen;
        r.rejected          = reject_seen;
        if (last) begin
            clear_name_state();
        end
        return r;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            clear_name_state();
            short_name_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                short_name_q.push_back(short_name_step(i_char_code, i_last_char));
            end
            if (i_res_valid && i_res_ready) begin
                if (short_name_q.size() == 0) begin
                    $error("result beat with no byte waiting for it");
                    mismatch_cnt++;
                end else begin
                    want = short_name_q.pop_front();
                    check_field("out_valid", want.out_valid, i_out_valid);
                    check_field("out_char", want.out_char, i_out_char);
                    check_field("name_done", want.name_done, i_name_done);
                    check_field("truncated", want.truncated, i_truncated);
                    check_field("case_converted", want.case_converted, i_case_converted);
                    check_field("bad_char_replaced", want.bad_char_replaced,
                                i_bad_char_replaced);
                    check_field("rejected", want.rejected, i_rejected);
                end
            end
        end
        o_pending <= short_name_q.size();
    end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives file names byte by byte into the 8.3 short-name converter: a few
// directed names for the corner cases, then random names, mostly well formed,
// under three idle patterns on the two channels. The checker beside the
// block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module testbench
    import u2d_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [7:0] t_byte_q[$];

    localparam string LEGAL_CHARS = "abcdefghijklmnopqrstuvwxyz0123456789_^$~!#%&-{}'`()@";

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_char_code;
    logic       i_last_char;
    logic       o_res_valid;
    logic       i_res_ready;
    logic       o_out_valid;
    logic [7:0] o_out_char;
    logic       o_name_done;
    logic       o_truncated;
    logic       o_case_converted;
    logic       o_bad_char_replaced;
    logic       o_rejected;
    int         pending;
    int         mismatches;

    int snd_idle;
    int rcv_idle;
    int bytes_sent;

    unix_to_dos_short_name DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_char_code         (i_char_code),
        .i_last_char         (i_last_char),
        .o_res_valid         (o_res_valid),
        .i_res_ready         (i_res_ready),
        .o_out_valid         (o_out_valid),
        .o_out_char          (o_out_char),
        .o_name_done         (o_name_done),
        .o_truncated         (o_truncated),
        .o_case_converted    (o_case_converted),
        .o_bad_char_replaced (o_bad_char_replaced),
        .o_rejected          (o_rejected)
    );

    short_name_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .i_in_ready          (o_in_ready),
        .i_char_code         (i_char_code),
        .i_last_char         (i_last_char),
        .i_res_valid         (o_res_valid),
        .i_res_ready         (i_res_ready),
        .i_out_valid         (o_out_valid),
        .i_out_char          (o_out_char),
        .i_name_done         (o_name_done),
        .i_truncated         (o_truncated),
        .i_case_converted    (o_case_converted),
        .i_bad_char_replaced (o_bad_char_replaced),
        .i_rejected          (o_rejected),
        .o_pending           (pending),
        .o_mismatches        (mismatches)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #1ms;
        $display("Some tests failed");
        $finish;
    end

    // Result side stalls at random at the current rate.
    always @(posedge i_clk) begin
        i_res_ready <= ($urandom_range(99) >= rcv_idle);
    end

    // Sends one name, last flag on its final byte. Valid stays high across
    // back-to-back beats and only drops while the sender idles.
    task automatic send_bytes(input t_byte_q name_bytes);
        for (int i = 0; i < name_bytes.size(); i++) begin
            while ($urandom_range(99) < snd_idle) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
            i_in_valid  <= 1'b1;
            i_char_code <= name_bytes[i];
            i_last_char <= (i == name_bytes.size() - 1);
            do begin
                @(posedge i_clk);
            end while (!o_in_ready);
            bytes_sent++;
        end
    endtask

    function automatic logic [7:0] random_name_char();
        int         pick;
        logic [7:0] c;
        pick = $urandom_range(99);
        if (pick < 50) begin
            c = LEGAL_CHARS[$urandom_range(LEGAL_CHARS.len() - 1)];
        end else if (pick < 70) begin
            c = 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
        end else if (pick < 97) begin
            c = 8'($urandom_range(1, 255));
            if (c == CH_DOT) begin
                c = CH_DOLLAR;
            end
        end else begin
            c = CH_NUL;
        end
        return c;
    endfunction

    task automatic send_random_name();
        t_byte_q name_bytes;
        int      shape;
        int      name_len;
        int      ext_len;
        shape = $urandom_range(99);
        if (shape < 90) begin
            name_len = ($urandom_range(7) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
            for (int i = 0; i < name_len; i++) begin
                name_bytes.push_back(random_name_char());
            end
            if ($urandom_range(3) != 0) begin
                name_bytes.push_back(CH_DOT);
                ext_len = ($urandom_range(7) == 0) ? 4 : $urandom_range(0, 3);
                for (int i = 0; i < ext_len; i++) begin
                    name_bytes.push_back(random_name_char());
                end
            end
            // A stray dot somewhere can turn a good name into a broken one.
            if (shape >= 80) begin
                name_bytes.insert($urandom_range(name_bytes.size()), CH_DOT);
            end
        end else begin
            name_len = $urandom_range(1, 6);
            for (int i = 0; i < name_len; i++) begin
                name_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
        send_bytes(name_bytes);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_char_code = 8'h00;
        i_last_char = 1'b0;
        i_res_ready = 1'b0;
        snd_idle    = 38;
        rcv_idle    = 51;
        bytes_sent  = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Leading dot, then a byte after the rejection.
        send_bytes('{CH_DOT, "x"});
        // Empty name: a lone NUL that ends it.
        send_bytes('{CH_NUL});
        // Capital, a high byte, a control byte, then a second dot.
        send_bytes('{"Q", 8'hFF, 8'h01, CH_DOT, "~", CH_DOT});
        // Extension one byte too long.
        send_bytes('{"a", CH_DOT, "b", "c", "d", "e"});
        // Nine name bytes, the last one dropped; NUL closes the name.
        send_bytes('{"0", "1", "2", "3", "4", "5", "6", "7", "8", CH_NUL});

        for (int ph = 0; ph < 3; ph++) begin
            snd_idle = (ph == 0) ? 38 : (ph == 1) ? 51 : 0;
            rcv_idle = (ph == 0) ? 51 : (ph == 1) ? 38 : 0;
            while (bytes_sent < 25 + (ph + 1) * 335) begin
                send_random_name();
            end
        end
        i_in_valid <= 1'b0;
        @(posedge i_clk);

        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (5) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/u2d_pkg.sv
rtl/core/u2d_char_map.sv
rtl/core/unix_to_dos_short_name.sv
tb/short_name_checker.sv
tb/testbench.sv
